/* src/tod_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time-of-day parser package
// Shared types and constants for the character-at-a-time time-of-day parser:
// the parse phase codes, the parser state record and the result record.
// ----------------------------------------------------------------------------
package tod_pkg;

	// Parse phases. Codes 11..15 are unused and act like the drop phase.
	typedef enum logic [3:0] {
		PH_MARKER = 4'd0,
		PH_HOUR   = 4'd1,
		PH_MIN    = 4'd2,
		PH_SEC    = 4'd3,
		PH_SUF_H  = 4'd4,
		PH_SUF_M  = 4'd5,
		PH_SUF_S  = 4'd6,
		PH_END_H  = 4'd7,
		PH_END_M  = 4'd8,
		PH_END_S  = 4'd9,
		PH_DROP   = 4'd10
	} tod_phase_t;

	// Character codes.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// Range limits and the afternoon offset.
	localparam logic [6:0] LIMIT_HOUR = 7'd23;
	localparam logic [6:0] LIMIT_MIN  = 7'd59;
	localparam logic [6:0] LIMIT_SEC  = 7'd60;
	localparam logic [6:0] ACC_MAX    = 7'd127;
	localparam logic [4:0] PM_OFFSET  = 5'd12;

	// Field-count codes.
	localparam logic [1:0] FLD_H   = 2'd0;
	localparam logic [1:0] FLD_HM  = 2'd1;
	localparam logic [1:0] FLD_HMS = 2'd2;

	// Parser state carried from one character to the next.
	typedef struct packed {
		tod_phase_t  phase;
		logic [6:0]  accum;
		logic        digit_seen;
		logic [4:0]  held_hour;
		logic [5:0]  held_minute;
		logic        pm_flag;
	} tod_state_t;

	// One parsed result and whether the character produces it.
	typedef struct packed {
		logic        emit;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [1:0]  fields_present;
		logic        status;
	} tod_result_t;

	localparam tod_state_t STATE_CLEAR = '{
		phase:       PH_MARKER,
		accum:       7'd0,
		digit_seen:  1'b0,
		held_hour:   5'd0,
		held_minute: 6'd0,
		pm_flag:     1'b0
	};

endpackage
`default_nettype wire

/* src/time_of_day_text_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time-of-day text parser
// Takes one text byte per request and reports parsed HH[:MM[:SS]][am|pm]
// strings. Each string starts with a marker byte that is discarded and ends
// at NUL or whitespace; the terminator yields one result request.
//
// Input channel: in_valid / in_stall with char_code. Output channel:
// out_valid / out_stall with hour, minute, second, fields_present, status
// (status 1 flags a format or range error with all other fields zero).
// A byte is captured in an input register; when it advances, the parser
// state is updated by one pass of logic and the result is loaded into the
// output register, which raises out_valid for a terminator. One byte is
// accepted per cycle while the output is not blocked.
// When out_stall holds a pending result, the byte in the input register
// waits and in_stall rises; bytes that give no result still wait for it.
// Reset clears the parser to expect a marker byte and empties both
// registers.
// ----------------------------------------------------------------------------
module time_of_day_text_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] char_code,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [4:0]      hour,
	output logic [5:0]      minute,
	output logic [5:0]      second,
	output logic [1:0]      fields_present,
	output logic            status
);

	logic                 valid_s1;
	logic [7:0]           char_s1;
	tod_pkg::tod_state_t  state_q;
	tod_pkg::tod_state_t  state_nxt;
	tod_pkg::tod_result_t step_res;
	logic                 out_valid_q;
	tod_pkg::tod_result_t out_q;
	logic                 advance;

	// The captured byte moves on when the output register can take a result.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
		end
	end

	// Parser step.
	tod_step u_step (
		.cur       (state_q),
		.char_code (char_s1),
		.nxt       (state_nxt),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tod_pkg::STATE_CLEAR;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_res.emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.emit) begin
			out_q <= step_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign hour           = out_q.hour;
	assign minute         = out_q.minute;
	assign second         = out_q.second;
	assign fields_present = out_q.fields_present;
	assign status         = out_q.status;

endmodule
`default_nettype wire

/* src/tod_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time-of-day parser step
// Combinational update of the parser state for one character, together
// with the result that the character produces, if any.
// ----------------------------------------------------------------------------
module tod_step (
	input  wire tod_pkg::tod_state_t  cur,
	input  wire logic [7:0]           char_code,
	output tod_pkg::tod_state_t       nxt,
	output tod_pkg::tod_result_t      res
);

	logic [7:0]  lc;
	logic        is_term;
	logic        is_digit;
	logic        is_colon;
	logic        is_suffix;
	logic [10:0] acc_prod;
	logic [6:0]  acc_sat;
	logic [6:0]  limit;
	logic        num_ok;
	logic        emit_ok;
	logic        emit_err;
	logic [1:0]  fld;
	logic [4:0]  hour_base;
	logic [5:0]  minute_base;

	// Character classes.
	assign lc = (char_code >= tod_pkg::CH_UP_A && char_code <= tod_pkg::CH_UP_Z) ?
		char_code + tod_pkg::CASE_OFS : char_code;
	assign is_term = (char_code == tod_pkg::CH_NUL) || (char_code == tod_pkg::CH_SPACE) ||
		(char_code >= tod_pkg::CH_TAB && char_code <= tod_pkg::CH_CR);
	assign is_digit  = (char_code >= tod_pkg::CH_ZERO) && (char_code <= tod_pkg::CH_NINE);
	assign is_colon  = (char_code == tod_pkg::CH_COLON);
	assign is_suffix = (lc == tod_pkg::CH_A) || (lc == tod_pkg::CH_P);

	// Decimal accumulate (times ten plus digit), saturating at the register maximum.
	assign acc_prod = {1'b0, cur.accum, 3'b000} + {3'b000, cur.accum, 1'b0} +
		{7'd0, char_code[3:0] - tod_pkg::CH_ZERO[3:0]};
	assign acc_sat = (acc_prod > {4'd0, tod_pkg::ACC_MAX}) ? tod_pkg::ACC_MAX : acc_prod[6:0];

	// The range check that applies to the number being read.
	always_comb begin
		case (cur.phase)
			tod_pkg::PH_HOUR: limit = tod_pkg::LIMIT_HOUR;
			tod_pkg::PH_MIN:  limit = tod_pkg::LIMIT_MIN;
			default:          limit = tod_pkg::LIMIT_SEC;
		endcase
	end
	assign num_ok = cur.digit_seen && (cur.accum <= limit);

	// Next state.
	always_comb begin
		nxt = cur;
		case (cur.phase)
			tod_pkg::PH_MARKER: begin
				if (is_term) begin
					nxt = tod_pkg::STATE_CLEAR;
				end else begin
					nxt.phase      = tod_pkg::PH_HOUR;
					nxt.accum      = 7'd0;
					nxt.digit_seen = 1'b0;
				end
			end
			tod_pkg::PH_HOUR, tod_pkg::PH_MIN, tod_pkg::PH_SEC: begin
				if (is_digit) begin
					nxt.accum      = acc_sat;
					nxt.digit_seen = 1'b1;
				end else if (!is_term && !is_colon && !is_suffix) begin
					nxt.phase = tod_pkg::PH_DROP;
				end else if (!num_ok) begin
					if (is_term) begin
						nxt = tod_pkg::STATE_CLEAR;
					end else begin
						nxt.phase = tod_pkg::PH_DROP;
					end
				end else if (is_term) begin
					nxt = tod_pkg::STATE_CLEAR;
				end else begin
					// Bank the finished field.
					if (cur.phase == tod_pkg::PH_HOUR) begin
						nxt.held_hour = cur.accum[4:0];
					end
					if (cur.phase == tod_pkg::PH_MIN) begin
						nxt.held_minute = cur.accum[5:0];
					end
					if (is_colon) begin
						case (cur.phase)
							tod_pkg::PH_HOUR: nxt.phase = tod_pkg::PH_MIN;
							tod_pkg::PH_MIN:  nxt.phase = tod_pkg::PH_SEC;
							default:          nxt.phase = tod_pkg::PH_DROP;
						endcase
						if (cur.phase != tod_pkg::PH_SEC) begin
							nxt.accum      = 7'd0;
							nxt.digit_seen = 1'b0;
						end
					end else begin
						nxt.pm_flag = (lc == tod_pkg::CH_P);
						case (cur.phase)
							tod_pkg::PH_HOUR: nxt.phase = tod_pkg::PH_SUF_H;
							tod_pkg::PH_MIN:  nxt.phase = tod_pkg::PH_SUF_M;
							default:          nxt.phase = tod_pkg::PH_SUF_S;
						endcase
					end
				end
			end
			tod_pkg::PH_SUF_H, tod_pkg::PH_SUF_M, tod_pkg::PH_SUF_S: begin
				if (is_term) begin
					nxt = tod_pkg::STATE_CLEAR;
				end else if (lc == tod_pkg::CH_M) begin
					case (cur.phase)
						tod_pkg::PH_SUF_H: nxt.phase = tod_pkg::PH_END_H;
						tod_pkg::PH_SUF_M: nxt.phase = tod_pkg::PH_END_M;
						default:           nxt.phase = tod_pkg::PH_END_S;
					endcase
				end else begin
					nxt.phase = tod_pkg::PH_DROP;
				end
			end
			tod_pkg::PH_END_H, tod_pkg::PH_END_M, tod_pkg::PH_END_S: begin
				if (is_term) begin
					nxt = tod_pkg::STATE_CLEAR;
				end else begin
					nxt.phase = tod_pkg::PH_DROP;
				end
			end
			default: begin
				if (is_term) begin
					nxt = tod_pkg::STATE_CLEAR;
				end else begin
					nxt.phase = tod_pkg::PH_DROP;
				end
			end
		endcase
	end

	// Decide whether a result is produced and how many fields it carries.
	always_comb begin
		emit_ok  = 1'b0;
		emit_err = 1'b0;
		fld      = tod_pkg::FLD_H;
		case (cur.phase)
			tod_pkg::PH_MARKER: begin
				emit_err = is_term;
			end
			tod_pkg::PH_HOUR, tod_pkg::PH_MIN, tod_pkg::PH_SEC: begin
				emit_ok  = is_term && num_ok;
				emit_err = is_term && !num_ok;
				case (cur.phase)
					tod_pkg::PH_HOUR: fld = tod_pkg::FLD_H;
					tod_pkg::PH_MIN:  fld = tod_pkg::FLD_HM;
					default:          fld = tod_pkg::FLD_HMS;
				endcase
			end
			tod_pkg::PH_SUF_H, tod_pkg::PH_END_H: begin
				emit_ok = is_term;
				fld     = tod_pkg::FLD_H;
			end
			tod_pkg::PH_SUF_M, tod_pkg::PH_END_M: begin
				emit_ok = is_term;
				fld     = tod_pkg::FLD_HM;
			end
			tod_pkg::PH_SUF_S, tod_pkg::PH_END_S: begin
				emit_ok = is_term;
				fld     = tod_pkg::FLD_HMS;
			end
			default: begin
				emit_err = is_term;
			end
		endcase
	end

	// A number ended by the terminator has not been banked yet, so take it directly.
	assign hour_base   = (cur.phase == tod_pkg::PH_HOUR) ? cur.accum[4:0] : cur.held_hour;
	assign minute_base = (cur.phase == tod_pkg::PH_MIN) ? cur.accum[5:0] : cur.held_minute;

	// Assemble the result fields; an error carries zeros.
	always_comb begin
		res        = '0;
		res.emit   = emit_ok || emit_err;
		res.status = emit_err;
		if (emit_ok) begin
			res.hour = (cur.pm_flag && hour_base < tod_pkg::PM_OFFSET) ?
				hour_base + tod_pkg::PM_OFFSET : hour_base;
			res.minute         = (fld != tod_pkg::FLD_H) ? minute_base : 6'd0;
			res.second         = (fld == tod_pkg::FLD_HMS) ? cur.accum[5:0] : 6'd0;
			res.fields_present = fld;
		end
	end

endmodule
`default_nettype wire
